/* rtl/rect_to_polar_spectrum_defines.svh */
// assertion macros for the rect_to_polar_spectrum block
`ifndef RECT_TO_POLAR_SPECTRUM_DEFINES_SVH
`define RECT_TO_POLAR_SPECTRUM_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define RTPS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtps check failed");

// next-cycle implication, sampled on clk, off during rst
`define RTPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtps check failed");

`endif

/* rtl/rtps_pkg.sv */
// shared constants and angle table for the rectangular to polar converter
package rtps_pkg;

  localparam int FIELD_W = 16;
  localparam int ANGLE_W = 28;

  localparam logic signed [ANGLE_W-1:0] ANGLE_PI = ANGLE_W'(52707179);
  localparam logic [FIELD_W-1:0] PHASE_PI = FIELD_W'(25736);

  localparam logic [ANGLE_W-1:0] ATAN_TAB [0:8] = '{
    ANGLE_W'(13176795), ANGLE_W'(7778716), ANGLE_W'(4110060),
    ANGLE_W'(2086331), ANGLE_W'(1047214), ANGLE_W'(524117),
    ANGLE_W'(262123), ANGLE_W'(131069), ANGLE_W'(65536)
  };

  // micro-rotation angle in units of 2^-24 radian
  function automatic logic signed [ANGLE_W-1:0] step_angle(input int i);
    logic signed [ANGLE_W-1:0] a;
    if (i < 9) begin
      a = ATAN_TAB[4'(i)];
    end else if (i <= 24) begin
      a = ANGLE_W'(1) << (24 - i);
    end else begin
      a = '0;
    end
    return a;
  endfunction

endpackage

/* rtl/rtps_in_if.sv */
// sample request channel: complex sample and spectrum markers
interface rtps_in_if import rtps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] real_part;
  logic signed [FIELD_W-1:0] imag_part;
  logic                      first_sample;
  logic                      last_sample;

  modport source (output valid, real_part, imag_part, first_sample, last_sample,
                  input ready);
  modport sink (input valid, real_part, imag_part, first_sample, last_sample,
                output ready);
endinterface

/* rtl/rtps_out_if.sv */
// result request channel: magnitude, phase and end marker
interface rtps_out_if import rtps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [FIELD_W-1:0] magnitude;
  logic signed [FIELD_W-1:0] phase;
  logic                      end_marker;

  modport source (output valid, magnitude, phase, end_marker, input ready);
  modport sink (input valid, magnitude, phase, end_marker, output ready);
endinterface

/* rtl/rect_to_polar_spectrum.sv */
// pipelined rectangular to polar converter: square root and cordic phase per sample
// path: input register, squares stage, sum-of-squares register, NS iteration
//   stages, final stage and output register; NS = max(CORDIC_STEPS, SAMPLE_WIDTH)
// throughput: one request per cycle while the skid stage is empty; each iteration
//   stage holds at most one cordic micro-rotation and one root bit, so depth grows with the larger count
// reset: rst (synchronous) clears all valid bits and the output skid stage
`include "rect_to_polar_spectrum_defines.svh"

module rect_to_polar_spectrum import rtps_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input logic       clk,
  input logic       rst,
  rtps_in_if.sink   samples,
  rtps_out_if.source results
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int NS  = (CORDIC_STEPS > W) ? CORDIC_STEPS : W;
  localparam int XW  = W + 18;                    // cordic x/y incl. gain growth
  localparam int SW  = 2 * W;                     // sum of squares
  localparam int EW  = (W > FIELD_W) ? W : FIELD_W;
  localparam int RW  = W + 1;                     // rounded root
  localparam int MW  = (RW > FIELD_W) ? RW : FIELD_W;

  // the whole pipeline moves unless the skid stage is holding a result
  logic en;

  // ---------------- stage 0: input register ----------------
  logic [EW-1:0] re_ext, im_ext;
  assign re_ext = EW'($unsigned(samples.real_part));
  assign im_ext = EW'($unsigned(samples.imag_part));

  logic                p0_v;
  logic signed [W-1:0] p0_re, p0_im;
  logic                p0_first, p0_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
    end else if (en) begin
      p0_v <= samples.valid;
    end
    if (en) begin
      p0_re    <= $signed(re_ext[W-1:0]);
      p0_im    <= $signed(im_ext[W-1:0]);
      p0_first <= samples.first_sample;
      p0_last  <= samples.last_sample;
    end
  end

  assign samples.ready = en;

  // ---------------- stage 1: squares and cordic pre-rotation ----------------
  logic                      p1_v;
  logic signed [SW-1:0]      p1_sq_re, p1_sq_im;
  logic signed [XW-1:0]      p1_x, p1_y;
  logic signed [ANGLE_W-1:0] p1_z;
  logic                      p1_first, p1_last, p1_zero, p1_neg;

  logic signed [XW-1:0] x_in, y_in;
  assign x_in = XW'(p0_re) <<< 16;
  assign y_in = XW'(p0_im) <<< 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= p0_v;
    end
    if (en) begin
      p1_sq_re <= p0_re * p0_re;
      p1_sq_im <= p0_im * p0_im;
      // left half plane: rotate by pi so the iterations see x >= 0
      if (p0_re < 0) begin
        p1_x <= -x_in;
        p1_y <= -y_in;
        p1_z <= (p0_im >= 0) ? ANGLE_PI : -ANGLE_PI;
      end else begin
        p1_x <= x_in;
        p1_y <= y_in;
        p1_z <= '0;
      end
      p1_first <= p0_first;
      p1_last  <= p0_last;
      p1_zero  <= (p0_re == '0) && (p0_im == '0);
      p1_neg   <= p0_re < 0;
    end
  end

  // ---------------- iteration stages ----------------
  // index 0 is the sum-of-squares register, index s+1 holds the state after step s
  logic                      it_v     [0:NS];
  logic signed [XW-1:0]      it_x     [0:NS];
  logic signed [XW-1:0]      it_y     [0:NS];
  logic signed [ANGLE_W-1:0] it_z     [0:NS];
  logic        [SW-1:0]      it_rem   [0:NS];
  logic        [SW-1:0]      it_root  [0:NS];
  logic                      it_first [0:NS];
  logic                      it_last  [0:NS];
  logic                      it_zero  [0:NS];
  logic                      it_neg   [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      it_v[0] <= 1'b0;
    end else if (en) begin
      it_v[0] <= p1_v;
    end
    if (en) begin
      it_x[0]     <= p1_x;
      it_y[0]     <= p1_y;
      it_z[0]     <= p1_z;
      it_rem[0]   <= $unsigned(p1_sq_re) + $unsigned(p1_sq_im);
      it_root[0]  <= '0;
      it_first[0] <= p1_first;
      it_last[0]  <= p1_last;
      it_zero[0]  <= p1_zero;
      it_neg[0]   <= p1_neg;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_iter
    logic signed [XW-1:0]      x_nx, y_nx;
    logic signed [ANGLE_W-1:0] z_nx;
    logic        [SW-1:0]      rem_nx, root_nx;

    if (s < CORDIC_STEPS) begin : g_rot
      localparam logic signed [ANGLE_W-1:0] ANG = step_angle(s);
      logic signed [XW-1:0] dx, dy;
      assign dx = it_y[s] >>> s;
      assign dy = it_x[s] >>> s;
      always_comb begin
        if (it_y[s] >= 0) begin
          x_nx = it_x[s] + dx;
          y_nx = it_y[s] - dy;
          z_nx = it_z[s] + ANG;
        end else begin
          x_nx = it_x[s] - dx;
          y_nx = it_y[s] + dy;
          z_nx = it_z[s] - ANG;
        end
      end
    end else begin : g_rot_pass
      assign x_nx = it_x[s];
      assign y_nx = it_y[s];
      assign z_nx = it_z[s];
    end

    if (s < W) begin : g_root
      // restoring square root, one result bit per stage
      localparam logic [SW-1:0] BIT = SW'(1) << (2 * (W - 1 - s));
      logic [SW-1:0] trial;
      assign trial = it_root[s] + BIT;
      always_comb begin
        if (it_rem[s] >= trial) begin
          rem_nx  = it_rem[s] - trial;
          root_nx = (it_root[s] >> 1) + BIT;
        end else begin
          rem_nx  = it_rem[s];
          root_nx = it_root[s] >> 1;
        end
      end
    end else begin : g_root_pass
      assign rem_nx  = it_rem[s];
      assign root_nx = it_root[s];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        it_v[s+1] <= 1'b0;
      end else if (en) begin
        it_v[s+1] <= it_v[s];
      end
      if (en) begin
        it_x[s+1]     <= x_nx;
        it_y[s+1]     <= y_nx;
        it_z[s+1]     <= z_nx;
        it_rem[s+1]   <= rem_nx;
        it_root[s+1]  <= root_nx;
        it_first[s+1] <= it_first[s];
        it_last[s+1]  <= it_last[s];
        it_zero[s+1]  <= it_zero[s];
        it_neg[s+1]   <= it_neg[s];
      end
    end
  end

  // ---------------- final stage: rounding, saturation, phase select ----------------
  logic [RW-1:0]             mag_full;
  logic [MW-1:0]             mag_ext;
  logic [FIELD_W-1:0]        mag_sat;
  logic signed [ANGLE_W-1:0] z_round;
  logic signed [FIELD_W-1:0] phase_sel;

  // rem = n - root^2, so round up once rem exceeds root
  assign mag_full = RW'(it_root[NS]) + RW'(it_rem[NS] > it_root[NS]);
  assign mag_ext  = MW'(mag_full);
  assign mag_sat  = (mag_ext > MW'(16'hFFFF)) ? 16'hFFFF : mag_ext[FIELD_W-1:0];
  assign z_round  = it_z[NS] + ANGLE_W'(1024);

  always_comb begin
    if (it_first[NS]) begin
      // dc bin: only the sign of the real part matters
      phase_sel = it_neg[NS] ? $signed(PHASE_PI) : '0;
    end else if (it_zero[NS]) begin
      phase_sel = '0;
    end else begin
      phase_sel = FIELD_W'(z_round >>> 11);
    end
  end

  logic                      fin_v;
  logic        [FIELD_W-1:0] fin_mag;
  logic signed [FIELD_W-1:0] fin_phase;
  logic                      fin_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
    end else if (en) begin
      fin_v <= it_v[NS];
    end
    if (en) begin
      fin_mag   <= mag_sat;
      fin_phase <= phase_sel;
      fin_last  <= it_last[NS];
    end
  end

  // ---------------- output register with skid stage ----------------
  // the skid stage catches the one result pushed while the output is stalled
  logic                      ov, sv;
  logic        [FIELD_W-1:0] o_mag, s_mag;
  logic signed [FIELD_W-1:0] o_phase, s_phase;
  logic                      o_last, s_last;

  assign en = ~sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (results.ready || !ov) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= fin_v;
      end
    end else if (fin_v && en) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (results.ready || !ov) begin
      if (sv) begin
        o_mag   <= s_mag;
        o_phase <= s_phase;
        o_last  <= s_last;
      end else begin
        o_mag   <= fin_mag;
        o_phase <= fin_phase;
        o_last  <= fin_last;
      end
    end else if (fin_v && en) begin
      s_mag   <= fin_mag;
      s_phase <= fin_phase;
      s_last  <= fin_last;
    end
  end

  assign results.valid      = ov;
  assign results.magnitude  = o_mag;
  assign results.phase      = o_phase;
  assign results.end_marker = o_last;

  // ---------------- checks ----------------
  // a result in the skid stage always has one ahead of it in the output register
  `RTPS_ASSERT_NOW(a_skid_behind_out, sv, ov)
  // the skid stage only fills while the output is stalled
  `RTPS_ASSERT_NOW(a_skid_fill_cause, $rose(sv), $past(ov && !results.ready))
  // a taken output drains the skid stage in the next cycle
  `RTPS_ASSERT_NEXT(a_skid_drains, sv && results.ready, !sv && ov)

endmodule

/* tb/testbench.sv */
// self-checking testbench for the rectangular to polar spectrum converter
`timescale 1ns / 1ps

module testbench import rtps_pkg::*; ();

  // run limits and test sizes
  localparam int CORDIC_ITERS    = 16;
  localparam int RANDOM_ITEMS    = 450;
  localparam int DRAIN_CYCLES    = 60;
  localparam int HOLD_CYCLES     = 400;
  localparam int HOLD_AT_RESULT  = 150;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DIRECTED_COUNT  = 24;

  // one converted sample as it leaves the block
  typedef struct packed {
    logic [FIELD_W-1:0]        magnitude;
    logic signed [FIELD_W-1:0] phase;
    logic                      end_marker;
  } polar_t;

  // one row of the directed table; known marks rows whose result is typed in
  typedef struct packed {
    logic signed [FIELD_W-1:0] re;
    logic signed [FIELD_W-1:0] im;
    logic                      first;
    logic                      last;
    logic                      known;
    logic [FIELD_W-1:0]        mag;
    logic signed [FIELD_W-1:0] ph;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rtps_in_if  samples_if ();
  rtps_out_if results_if ();

  rect_to_polar_spectrum i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  always #5 clk = ~clk;

  stim_row_t directed_rows [DIRECTED_COUNT];

  // results still owed by the block, oldest first
  polar_t expected_polar [$];
  polar_t arrived_want;

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned items_offered = 0;
  logic        sender_calm   = 1'b0;
  logic        receiver_calm = 1'b0;
  logic        hold_done     = 1'b0;

  // arctangent of 2^-i in units of 2^-24 radian
  function automatic longint arctan_units(input int i);
    longint a;
    case (i)
      0: a = 64'd13176795;
      1: a = 64'd7778716;
      2: a = 64'd4110060;
      3: a = 64'd2086331;
      4: a = 64'd1047214;
      5: a = 64'd524117;
      6: a = 64'd262123;
      7: a = 64'd131069;
      8: a = 64'd65536;
      default: a = (i <= 24) ? (longint'(1) << (24 - i)) : 64'd0;
    endcase
    return a;
  endfunction

  // amplitude and phase of one sample, bit exact
  function automatic polar_t predict_polar(input logic signed [FIELD_W-1:0] re_in,
                                           input logic signed [FIELD_W-1:0] im_in,
                                           input logic first, input logic last);
    longint          re;
    longint          im;
    longint          x;
    longint          y;
    longint          z;
    longint          dx;
    longint          dy;
    longint          phase_full;
    longint unsigned power;
    longint unsigned root;
    longint unsigned rem;
    longint unsigned probe;
    polar_t          r;
    re = longint'(re_in);
    im = longint'(im_in);

    // exact integer root, then round up past the midpoint
    power = longint'(re * re) + longint'(im * im);
    rem   = power;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > power) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (rem > root) root = root + 1;
    if (root > 64'd65535) root = 64'd65535;
    r.magnitude = root[FIELD_W-1:0];

    if (first) begin
      // dc bin: only the sign of the real part matters
      r.phase = (re < 0) ? PHASE_PI : '0;
    end else if (re == 0 && im == 0) begin
      r.phase = '0;
    end else begin
      x = re * 65536;
      y = im * 65536;
      z = 0;
      // left half plane: fold over and start from plus or minus pi
      if (x < 0) begin
        z = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + arctan_units(i);
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - arctan_units(i);
        end
      end
      phase_full = (z + 1024) >>> 11;
      r.phase = phase_full[FIELD_W-1:0];
    end
    r.end_marker = last;
    return r;
  endfunction

  // one sample part, weighted toward extremes, small values and powers of two
  function automatic logic signed [FIELD_W-1:0] pick_part();
    logic signed [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          3: v = 16'hffff;
          default: v = 16'h0001;
        endcase
      end
      1: v = FIELD_W'(int'($urandom_range(0, 32)) - 16);
      2: begin
        v = FIELD_W'(1 << $urandom_range(0, 14));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = FIELD_W'($urandom);
    endcase
    return v;
  endfunction

  // offer one request after a random gap and hold it until the block takes it
  task automatic offer_sample(input logic signed [FIELD_W-1:0] re,
                              input logic signed [FIELD_W-1:0] im,
                              input logic first, input logic last,
                              input polar_t want);
    int unsigned gap;
    // calm stretches come and go in blocks of requests
    if (items_offered % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      samples_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_if.valid        = 1'b1;
    samples_if.real_part    = re;
    samples_if.imag_part    = im;
    samples_if.first_sample = first;
    samples_if.last_sample  = last;
    // ready is read at the rising edge, before the block updates it
    do @(posedge clk); while (!samples_if.ready);
    expected_polar.push_back(want);
    items_offered++;
    @(negedge clk);
  endtask

  // main sequence: reset, directed table, random spectra, drain, verdict
  initial begin
    int unsigned sent;
    int unsigned len;
    logic        noisy;
    logic        first;
    logic        last;
    logic signed [FIELD_W-1:0] re;
    logic signed [FIELD_W-1:0] im;
    polar_t      want;

    samples_if.valid        = 1'b0;
    samples_if.real_part    = '0;
    samples_if.imag_part    = '0;
    samples_if.first_sample = 1'b0;
    samples_if.last_sample  = 1'b0;
    results_if.ready        = 1'b0;

    // zero vector, dc bins of both signs, axes, corners and unit steps
    directed_rows = '{
      '{16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0,     16'd0},
      '{16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1, 16'd0,     16'd0},
      '{16'h8000, 16'h0000, 1'b1, 1'b0, 1'b1, 16'd32768, PHASE_PI},
      '{16'h7fff, 16'h0000, 1'b1, 1'b1, 1'b1, 16'd32767, 16'd0},
      '{16'hffff, 16'h3039, 1'b1, 1'b0, 1'b1, 16'd12345, PHASE_PI},
      '{16'h0000, 16'h8000, 1'b1, 1'b0, 1'b1, 16'd32768, 16'd0},
      '{16'h8000, 16'h8000, 1'b1, 1'b1, 1'b1, 16'd46341, PHASE_PI},
      '{16'h7fff, 16'h7fff, 1'b1, 1'b0, 1'b1, 16'd46340, 16'd0},
      '{16'h7fff, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'h8000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'h0000, 16'h7fff, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'h0000, 16'h8000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'h7fff, 16'h7fff, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'h8000, 16'h7fff, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'h7fff, 16'h8000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'hffff, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'hffff, 16'hffff, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'h0001, 16'hffff, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'hffff, 16'h0001, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'h0001, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'h0000, 16'h0001, 1'b0, 1'b1, 1'b0, 16'd0,     16'd0},
      '{16'h5555, 16'haaaa, 1'b1, 1'b0, 1'b0, 16'd0,     16'd0},
      '{16'haaaa, 16'h5555, 1'b0, 1'b1, 1'b0, 16'd0,     16'd0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: typed expectations where obvious, predictor otherwise
    foreach (directed_rows[k]) begin
      if (directed_rows[k].known) begin
        want = '{directed_rows[k].mag, directed_rows[k].ph, directed_rows[k].last};
      end else begin
        want = predict_polar(directed_rows[k].re, directed_rows[k].im,
                             directed_rows[k].first, directed_rows[k].last);
      end
      offer_sample(directed_rows[k].re, directed_rows[k].im,
                   directed_rows[k].first, directed_rows[k].last, want);
    end

    // random spectra: mostly well-formed first..last runs, some with stray markers
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      noisy = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < len; k++) begin
        if (noisy) begin
          first = 1'($urandom_range(0, 1));
          last  = 1'($urandom_range(0, 1));
        end else begin
          first = (k == 0);
          last  = (k == len - 1);
        end
        re = pick_part();
        im = pick_part();
        offer_sample(re, im, first, last, predict_polar(re, im, first, last));
        sent++;
      end
    end
    samples_if.valid = 1'b0;

    // wait for every owed result, then watch for strays
    while (expected_polar.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("rect_to_polar_spectrum: match");
    end else begin
      $display("rect_to_polar_spectrum: mismatch");
    end
    $finish;
  end

  // result side: random stalls per request, calm stretches, one long hold-off
  initial begin
    wait (rst == 1'b0);
    forever begin
      int unsigned stall;
      if (results_seen % 32 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      if (!hold_done && results_seen == HOLD_AT_RESULT) begin
        // long hold-off so the pipeline fills and backs up into the input
        results_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        stall = receiver_calm ? 0 : $urandom_range(0, 15);
        if (stall != 0) begin
          results_if.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      results_if.ready = 1'b1;
      do @(posedge clk); while (!results_if.valid);
      results_seen++;
      @(negedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_polar.size() == 0) begin
        $display("%0t: unexpected result magnitude %0d phase %0d end %0b", $time,
                 results_if.magnitude, results_if.phase, results_if.end_marker);
        error_count++;
      end else begin
        arrived_want = expected_polar.pop_front();
        if (results_if.magnitude !== arrived_want.magnitude) begin
          $display("%0t: magnitude expected %0d actual %0d", $time,
                   arrived_want.magnitude, results_if.magnitude);
          error_count++;
        end
        if (results_if.phase !== arrived_want.phase) begin
          $display("%0t: phase expected %0d actual %0d", $time,
                   arrived_want.phase, results_if.phase);
          error_count++;
        end
        if (results_if.end_marker !== arrived_want.end_marker) begin
          $display("%0t: end marker expected %0b actual %0b", $time,
                   arrived_want.end_marker, results_if.end_marker);
          error_count++;
        end
      end
    end
  end

  // watchdog on a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_polar.size());
      $display("rect_to_polar_spectrum: mismatch");
      $finish;
    end
  end

endmodule
